[hdl/timed_switch_event_table_top_assert.svh]
// assertion macros shared by the timed switch event table
`ifndef TIMED_SWITCH_EVENT_TABLE_TOP_ASSERT_SVH
`define TIMED_SWITCH_EVENT_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSET_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tset check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSET_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tset check failed");

`endif

[hdl/tset_pkg.sv]
package tset_pkg;

  // result kinds
  localparam logic [1:0] KIND_SWITCH   = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_REFUSED  = 2'd2;

  // input function codes
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // most switch actions one tick may produce
  localparam int MAX_RESULTS = 16;
  localparam int FOUND_W     = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic        func;
    logic [10:0] minute_of_day;
    logic [7:0]  light_num;
    logic        turn_on;
  } tset_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] target_light;
    logic       drive_on;
    logic       last;
  } tset_result_t;

  typedef struct packed {
    logic [10:0] minute;
    logic [7:0]  light;
    logic        on;
  } tset_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INSERT,
    ST_READ,
    ST_COMPARE,
    ST_FLUSH
  } tset_state_t;

  // what goes into the output register
  typedef enum logic [1:0] {
    OUT_STATUS,
    OUT_PEND,
    OUT_PEND_LAST
  } tset_out_sel_t;

  typedef struct packed {
    logic          load_item;
    logic          wr_entry;
    logic          rd_en;
    logic          idx_clr;
    logic          idx_inc;
    logic          pend_load;
    logic          out_load;
    tset_out_sel_t out_sel;
  } tset_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic full;
    logic empty;
    logic hit;
    logic last_entry;
    logic cap;
    logic pend_valid;
    logic out_free;
  } tset_sts_t;

endpackage

[hdl/tset_ctrl.sv]
module tset_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  tset_pkg::tset_sts_t sts,
  output tset_pkg::tset_cmd_t cmd
);
  import tset_pkg::*;

  tset_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.out_sel = OUT_STATUS;
    item_stall  = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_insert) begin
          state_next = ST_INSERT;
        end else if (sts.empty) begin
          state_next = ST_IDLE;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_INSERT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_STATUS;
          cmd.wr_entry = !sts.full;
          state_next   = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        // a new hit pushes the held one out, which needs a free output slot
        if (!(sts.hit && sts.pend_valid && !sts.out_free)) begin
          if (sts.hit) begin
            cmd.pend_load = 1'b1;
            if (sts.pend_valid) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = OUT_PEND;
            end
          end
          if ((sts.hit && sts.cap) || sts.last_entry) begin
            state_next = (sts.hit || sts.pend_valid) ? ST_FLUSH : ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_PEND_LAST;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/tset_dp.sv]
module tset_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tset_pkg::tset_item_t   item,
  output tset_pkg::tset_result_t result,
  output logic                  result_valid,
  input  logic                  result_stall,
  input  tset_pkg::tset_cmd_t    cmd,
  output tset_pkg::tset_sts_t    sts
);
  import tset_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tset_item_t   item_q;
  tset_entry_t  table_mem [TABLE_DEPTH];
  tset_entry_t  rd_q;
  logic [CW-1:0] entry_count;
  logic [AW-1:0] idx;
  logic [FOUND_W-1:0] found;
  logic         pend_valid;
  logic [7:0]   pend_light;
  logic         pend_on;
  tset_result_t result_next;
  logic         out_free;

  // item register
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
  end

  // entry table, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      table_mem[entry_count[AW-1:0]] <= '{minute: item_q.minute_of_day,
                                          light:  item_q.light_num,
                                          on:     item_q.turn_on};
    end
    if (cmd.rd_en) begin
      rd_q <= table_mem[idx];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.wr_entry) begin
      entry_count <= entry_count + CW'(1);
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  // held match and match count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (cmd.load_item) begin
      pend_valid <= 1'b0;
      found      <= '0;
    end else if (cmd.pend_load) begin
      pend_valid <= 1'b1;
      found      <= found + FOUND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_light <= rd_q.light;
      pend_on    <= rd_q.on;
    end
  end

  // output payload select
  always_comb begin
    result_next = '0;
    unique case (cmd.out_sel)
      OUT_STATUS: begin
        result_next.kind = sts.full ? KIND_REFUSED : KIND_ACCEPTED;
        result_next.last = 1'b1;
      end
      OUT_PEND: begin
        result_next.kind         = KIND_SWITCH;
        result_next.target_light = pend_light;
        result_next.drive_on     = pend_on;
        result_next.last         = 1'b0;
      end
      OUT_PEND_LAST: begin
        result_next.kind         = KIND_SWITCH;
        result_next.target_light = pend_light;
        result_next.drive_on     = pend_on;
        result_next.last         = 1'b1;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // output register
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= result_next;
    end
  end

  // status back to the controller
  always_comb begin
    sts.is_insert  = (item_q.func == FUNC_INSERT);
    sts.full       = (entry_count == CW'(TABLE_DEPTH));
    sts.empty      = (entry_count == '0);
    sts.hit        = (rd_q.minute == item_q.minute_of_day);
    sts.last_entry = ((CW'(idx) + CW'(1)) == entry_count);
    sts.cap        = (found == FOUND_W'(MAX_RESULTS - 1));
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

endmodule

[hdl/timed_switch_event_table_top.sv]
// Light scheduler: a table of timed switch actions.
// Input channel (item, item_valid, item_stall): func = insert appends an
// entry (minute, light, on/off); func = tick carries the current minute.
// Output channel (result, result_valid, result_stall) carries results.
// An insert gives one status result, accepted or refused when the table is
// full, loaded into the output register from the insert state after the
// dispatch state. A tick scans the stored entries in insertion order,
// reading each from memory and then comparing it, and gives one switch
// action per matching entry; the final one has last set, and at most 16
// actions come from one tick. A tick with no match gives nothing. The
// entry table has a single read port. item_stall is high until the item is
// finished. The next item can transfer while the last result still waits
// in the output register. A stalled receiver holds the output register
// and pauses the scan until the slot is free; nothing is dropped.
// Reset empties the table (fill count to zero) and clears result_valid.
`include "timed_switch_event_table_top_assert.svh"

module timed_switch_event_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  tset_pkg::tset_item_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tset_pkg::tset_result_t result
);
  import tset_pkg::*;

  tset_cmd_t cmd;
  tset_sts_t sts;

  // sequencer
  tset_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  // table, scan and output register
  tset_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // checks
  `TSET_ASSERT_NOW(a_no_write_when_full, cmd.wr_entry, !sts.full)
  `TSET_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, sts.out_free)
  `TSET_ASSERT_NEXT(a_no_result_after_transfer, item_valid && !item_stall, !cmd.out_load)
  `TSET_ASSERT_NEXT(a_read_then_compare, cmd.rd_en, !cmd.rd_en)

endmodule

[tb/sv/timed_switch_event_table_top_tb.sv]
module timed_switch_event_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tset_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int QUIET_LIMIT   = 5000;
  // drain time covers a full scan of the table plus the insert path
  localparam int DRAIN_CYCLES  = 2 + 2 * TABLE_DEPTH + 8;
  localparam int NUM_PHASES    = 3;
  localparam logic [10:0] MIN_LATE = 11'd777;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_stall;
  tset_item_t   item;
  logic         result_valid;
  logic         result_stall;
  tset_result_t result;

  // schedule table as the block should hold it
  logic [10:0]  sched_minute [TABLE_DEPTH];
  logic [7:0]   sched_light  [TABLE_DEPTH];
  logic         sched_on     [TABLE_DEPTH];
  int           sched_count;

  tset_item_t   pending_items[$];
  tset_result_t expected_results[$];

  int           items_queued;
  int           items_taken;
  int           mismatch_count;
  int           quiet_cycles;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         item_accepted;

  timed_switch_event_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic tset_item_t make_item(logic func, int minute, int light, logic on);
    tset_item_t it;
    it.func          = func;
    it.minute_of_day = minute[10:0];
    it.light_num     = light[7:0];
    it.turn_on       = on;
    return it;
  endfunction

  // expected results of one accepted item, updating the schedule table
  function automatic void schedule_apply(tset_item_t it);
    tset_result_t r;
    int hits;
    int k;
    r = '0;
    if (it.func == FUNC_INSERT) begin
      r.last = 1'b1;
      if (sched_count >= TABLE_DEPTH) begin
        r.kind = KIND_REFUSED;
      end else begin
        sched_minute[sched_count] = it.minute_of_day;
        sched_light[sched_count]  = it.light_num;
        sched_on[sched_count]     = it.turn_on;
        sched_count++;
        r.kind = KIND_ACCEPTED;
      end
      expected_results.push_back(r);
    end else begin
      hits = 0;
      for (int i = 0; i < sched_count; i++)
        if (sched_minute[i] == it.minute_of_day && hits < MAX_RESULTS) hits++;
      k = 0;
      for (int i = 0; i < sched_count; i++) begin
        if (sched_minute[i] == it.minute_of_day && k < hits) begin
          r.kind         = KIND_SWITCH;
          r.target_light = sched_light[i];
          r.drive_on     = sched_on[i];
          r.last         = (k == hits - 1);
          expected_results.push_back(r);
          k++;
        end
      end
    end
  endfunction

  function automatic tset_item_t random_item();
    int pick;
    int minute;
    pick = $urandom_range(99);
    if (pick < 15)
      return make_item(FUNC_INSERT, $urandom_range(2047), $urandom_range(255), $urandom_range(1));
    // most ticks hit a stored minute so the scan produces actions
    case ($urandom_range(5))
      0:       minute = 0;
      1:       minute = 1439;
      2:       minute = 2047;
      3:       minute = MIN_LATE;
      4:       minute = $urandom_range(1439);
      default: minute = $urandom_range(2047);
    endcase
    if (pick >= 85) minute = $urandom_range(2047);
    return make_item(FUNC_TICK, minute, $urandom_range(255), $urandom_range(1));
  endfunction

  task automatic queue_item(input tset_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_directed();
    queue_item(make_item(FUNC_TICK, 0, 0, 1'b0));          // empty table
    queue_item(make_item(FUNC_INSERT, 0, 0, 1'b0));
    queue_item(make_item(FUNC_INSERT, 1439, 255, 1'b1));
    queue_item(make_item(FUNC_INSERT, 2047, 8'hAA, 1'b1)); // minute past end of day
    queue_item(make_item(FUNC_TICK, 0, 255, 1'b1));        // partly filled table
    queue_item(make_item(FUNC_TICK, 2047, 0, 1'b0));
    // fill the rest: mostly minute zero for a long burst of actions
    for (int i = 3; i < TABLE_DEPTH; i++)
      queue_item(make_item(FUNC_INSERT, (i % 4 == 3) ? int'(MIN_LATE) : 0,
                           $urandom_range(255), $urandom_range(1)));
    queue_item(make_item(FUNC_INSERT, 2047, 255, 1'b1));   // table full
    queue_item(make_item(FUNC_INSERT, 0, 0, 1'b0));        // table full
    queue_item(make_item(FUNC_TICK, 0, 8'h55, 1'b0));
    queue_item(make_item(FUNC_TICK, MIN_LATE, 0, 1'b1));
    queue_item(make_item(FUNC_TICK, 1439, 255, 1'b1));
    queue_item(make_item(FUNC_TICK, 5, 0, 1'b0));          // no match
  endtask

  // item driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || item_accepted) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (!rst) result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    tset_result_t want;
    logic item_xfer;
    logic result_xfer;
    if (!rst) begin
      item_xfer   = item_valid && !item_stall;
      result_xfer = result_valid && !result_stall;
      item_accepted <= item_xfer;
      if (item_xfer) begin
        schedule_apply(item);
        items_taken++;
      end
      if (result_xfer) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d light %0d on %0d last %0d",
                                    result.kind, result.target_light, result.drive_on,
                                    result.last));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", result.kind, want.kind);
          check_field("target_light", result.target_light, want.target_light);
          check_field("drive_on", result.drive_on, want.drive_on);
          check_field("last", result.last, want.last);
        end
      end
      if (item_xfer || result_xfer) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int send_pct [NUM_PHASES];
    int recv_pct [NUM_PHASES];
    send_pct = '{18, 70, 0};
    recv_pct = '{70, 18, 0};
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    result_stall   = 1'b0;
    item_accepted  = 1'b0;
    sched_count    = 0;
    items_queued   = 0;
    items_taken    = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = send_pct[0];
    recv_stall_pct = recv_pct[0];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 0) queue_directed();
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
        queue_item(random_item());
      do @(negedge clk);
      while (items_taken != items_queued || expected_results.size() != 0);
      @(posedge clk);
    end
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/tset_pkg.sv
hdl/tset_ctrl.sv
hdl/tset_dp.sv
hdl/timed_switch_event_table_top.sv
tb/sv/timed_switch_event_table_top_tb.sv
